[sv/mdfe_pkg.sv]
// Shared types and constants for the depth-first maze explorer.
// No dependencies; imported by the explorer top level.
package mdfe_pkg;

    // Absolute directions.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // Operation codes carried in the input beat's user field.
    localparam logic OP_EXPLORE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // Configuration register indexes.
    localparam int   CFG_IDX_W    = 1;
    localparam int   CFG_DATA_W   = 4;
    localparam logic CFG_GOAL_ROW = 1'b0;
    localparam logic CFG_GOAL_COL = 1'b1;
    localparam logic [3:0] GOAL_RESET = 4'd7;

    // One cell entry, without the visited bit, which lives in its own store.
    // walls[d] is the wall on side d of the cell.
    typedef struct packed {
        logic [3:0] walls;
        logic [1:0] back_ptr;
        logic       exhausted;
    } cell_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_PROBE,
        ST_CHECK,
        ST_WB_CUR,
        ST_WB_DST,
        ST_EMIT
    } state_t;

endpackage

[sv/mdfe_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module mdfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/maze_depth_first_explorer_unit.sv]
// Depth-first maze explorer: top level with sequencer and cell stores.
// Depends on mdfe_pkg and mdfe_ram.
//
// This block walks a GRID_SIDE x GRID_SIDE maze by depth-first search, one
// input beat per robot step. An explore beat carries the front, left and right
// wall flags sensed at the current cell; a clear beat wipes all visited marks.
// Every input beat yields exactly one output beat with the move taken, the
// turn before it, the new position and the goal and stuck flags. The cell
// store sits in a RAM with one read and one write port, so a step is worked
// out by a small sequencer that reads the current cell, then probes the
// neighbours north, east, south and west one at a time through the same read
// port, and finally writes back the current cell and, on a forward move, the
// entered cell. An explore beat passes through a probe state for each
// direction that it tries, and a check state as well for each direction that
// needs a neighbour read. A clear beat sweeps the visited store at one entry
// per cycle. After reset the block runs a fill pass over every cell that
// writes the border walls into the store; s_tready stays low until it ends,
// while configuration writes are taken throughout. A finished result waits in
// the output register, so the next input beat is accepted while the previous
// result is still unclaimed.
module maze_depth_first_explorer_unit
    import mdfe_pkg::*;
#(
    parameter int GRID_SIDE = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Bits from 0: wall_front, wall_left, wall_right, zero fill.
    input  logic [7:0]            s_tdata,
    // Bit 0: operation.
    input  logic [0:0]            s_tuser,

    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Bits from 0: move_dir[1:0], turn[3:2], moved[4], backtracking[5],
    // goal_reached[6], stuck[7], pos_row[11:8], pos_col[15:12].
    output logic [15:0]           m_tdata,

    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int RW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMPW  = ((RW > CFG_DATA_W) ? RW : CFG_DATA_W) + 1;
    localparam int CW    = $bits(cell_t);
    localparam logic [RW-1:0] LAST_IDX = RW'(GRID_SIDE - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [RW-1:0] c);
        return AW'(r) * AW'(GRID_SIDE) + AW'(c);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;
    logic [1:0]      dir_reg, dir_next;
    logic [1:0]      move_dir_reg, move_dir_next;
    logic            found_reg, found_next;
    logic            moved_reg, moved_next;
    logic            back_reg, back_next;
    logic            stuck_reg, stuck_next;
    cell_t           cur_cell_reg, cur_cell_next;
    cell_t           nb_cell_reg, nb_cell_next;
    logic [2:0]      sense_reg, sense_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [RW-1:0]   cur_col_reg, cur_col_next;
    logic [1:0]      heading_reg, heading_next;
    logic [3:0]      goal_row_reg, goal_row_next;
    logic [3:0]      goal_col_reg, goal_col_next;
    logic [RW-1:0]   sweep_row_reg, sweep_row_next;
    logic [RW-1:0]   sweep_col_reg, sweep_col_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [15:0]     m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Cell stores: walls, back pointer and exhausted bit in one RAM,
    // visited bits in another so that a clear only has to write zeros.
    // ------------------------------------------------------------------
    logic            cell_we;
    logic [AW-1:0]   cell_waddr;
    logic [CW-1:0]   cell_wdata;
    logic [CW-1:0]   cell_rdata;
    logic            vis_we;
    logic [AW-1:0]   vis_waddr;
    logic [0:0]      vis_wdata;
    logic [0:0]      vis_rdata;
    logic [AW-1:0]   rd_addr;

    mdfe_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (rd_addr),
        .rdata (cell_rdata)
    );

    mdfe_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (rd_addr),
        .rdata (vis_rdata)
    );

    // ------------------------------------------------------------------
    // Shared neighbour unit: the cell next to the current one in sel_dir.
    // During the scan it follows the probe counter, afterwards the chosen move.
    // ------------------------------------------------------------------
    logic [1:0]      sel_dir;
    logic            nbr_ok;
    logic [RW-1:0]   nbr_row;
    logic [RW-1:0]   nbr_col;
    logic [AW-1:0]   nbr_addr;
    logic [AW-1:0]   cur_addr;
    logic [AW-1:0]   sweep_addr;

    assign sel_dir = (state_reg == ST_PROBE || state_reg == ST_CHECK) ? dir_reg
                                                                       : move_dir_reg;

    always_comb begin
        nbr_row = cur_row_reg;
        nbr_col = cur_col_reg;
        nbr_ok  = 1'b0;
        unique case (sel_dir)
            DIR_N: begin
                nbr_ok  = (cur_row_reg != '0);
                nbr_row = cur_row_reg - RW'(1);
            end
            DIR_E: begin
                nbr_ok  = (cur_col_reg != LAST_IDX);
                nbr_col = cur_col_reg + RW'(1);
            end
            DIR_S: begin
                nbr_ok  = (cur_row_reg != LAST_IDX);
                nbr_row = cur_row_reg + RW'(1);
            end
            DIR_W: begin
                nbr_ok  = (cur_col_reg != '0);
                nbr_col = cur_col_reg - RW'(1);
            end
        endcase
    end

    assign nbr_addr   = cell_addr(nbr_row, nbr_col);
    assign cur_addr   = cell_addr(cur_row_reg, cur_col_reg);
    assign sweep_addr = cell_addr(sweep_row_reg, sweep_col_reg);
    assign rd_addr    = (state_reg == ST_PROBE) ? nbr_addr : cur_addr;

    // Cell as it reads from the store, and with sensed walls merged on a
    // first visit. The sensors are relative to the heading.
    cell_t           rd_cell;
    cell_t           merged_cell;
    cell_t           border_cell;
    logic [1:0]      left_dir;
    logic [1:0]      right_dir;
    logic            sweep_last;
    logic            at_origin;
    logic            probe_blocked;
    logic            nb_free;

    assign rd_cell   = cell_t'(cell_rdata);
    assign left_dir  = heading_reg - 2'd1;
    assign right_dir = heading_reg + 2'd1;

    always_comb begin
        merged_cell = rd_cell;
        if (!vis_rdata[0]) begin
            merged_cell.walls[heading_reg] = rd_cell.walls[heading_reg] | sense_reg[0];
            merged_cell.walls[left_dir]    = rd_cell.walls[left_dir]    | sense_reg[1];
            merged_cell.walls[right_dir]   = rd_cell.walls[right_dir]   | sense_reg[2];
        end
    end

    always_comb begin
        border_cell              = '0;
        border_cell.walls[DIR_N] = (sweep_row_reg == '0);
        border_cell.walls[DIR_E] = (sweep_col_reg == LAST_IDX);
        border_cell.walls[DIR_S] = (sweep_row_reg == LAST_IDX);
        border_cell.walls[DIR_W] = (sweep_col_reg == '0);
    end

    assign sweep_last    = (sweep_row_reg == LAST_IDX) && (sweep_col_reg == LAST_IDX);
    assign at_origin     = (cur_row_reg == '0) && (cur_col_reg == '0);
    assign probe_blocked = cur_cell_reg.walls[dir_reg] ||
                           (cur_cell_reg.back_ptr == dir_reg) || !nbr_ok;
    assign nb_free       = !rd_cell.exhausted && !vis_rdata[0];

    // Result of the step, formed while the output register is loaded.
    logic [RW-1:0]   new_row;
    logic [RW-1:0]   new_col;
    logic [CMPW-1:0] new_row_w;
    logic [CMPW-1:0] new_col_w;
    logic [CMPW-1:0] goal_row_w;
    logic [CMPW-1:0] goal_col_w;
    logic            goal_hit;
    logic [1:0]      out_dir;
    logic [1:0]      out_turn;

    assign new_row    = moved_reg ? nbr_row : cur_row_reg;
    assign new_col    = moved_reg ? nbr_col : cur_col_reg;
    assign new_row_w  = CMPW'(new_row);
    assign new_col_w  = CMPW'(new_col);
    assign goal_row_w = CMPW'(goal_row_reg);
    assign goal_col_w = CMPW'(goal_col_reg);
    assign goal_hit   = (new_row_w == goal_row_w || new_row_w == goal_row_w + CMPW'(1)) &&
                        (new_col_w == goal_col_w || new_col_w == goal_col_w + CMPW'(1));
    assign out_dir    = moved_reg ? move_dir_reg : 2'd0;
    assign out_turn   = moved_reg ? (move_dir_reg - heading_reg) : 2'd0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            heading_reg   <= DIR_E;
            goal_row_reg  <= GOAL_RESET;
            goal_col_reg  <= GOAL_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            heading_reg   <= heading_next;
            goal_row_reg  <= goal_row_next;
            goal_col_reg  <= goal_col_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Step payload needs no reset.
    always_ff @(posedge aclk) begin
        dir_reg      <= dir_next;
        move_dir_reg <= move_dir_next;
        found_reg    <= found_next;
        moved_reg    <= moved_next;
        back_reg     <= back_next;
        stuck_reg    <= stuck_next;
        cur_cell_reg <= cur_cell_next;
        nb_cell_reg  <= nb_cell_next;
        sense_reg    <= sense_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_comb begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        move_dir_next  = move_dir_reg;
        found_next     = found_reg;
        moved_next     = moved_reg;
        back_next      = back_reg;
        stuck_next     = stuck_reg;
        cur_cell_next  = cur_cell_reg;
        nb_cell_next   = nb_cell_reg;
        sense_next     = sense_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        heading_next   = heading_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        goal_row_next  = (cfg_we && cfg_index == CFG_GOAL_ROW) ? cfg_wdata : goal_row_reg;
        goal_col_next  = (cfg_we && cfg_index == CFG_GOAL_COL) ? cfg_wdata : goal_col_reg;

        cell_we        = 1'b0;
        cell_waddr     = cur_addr;
        cell_wdata     = cur_cell_reg;
        vis_we         = 1'b0;
        vis_waddr      = cur_addr;
        vis_wdata      = 1'b1;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                // Fill pass after reset writes the border walls; a clear
                // pass only wipes the visited store.
                cell_we    = (state_reg == ST_INIT);
                cell_waddr = sweep_addr;
                cell_wdata = border_cell;
                vis_we     = 1'b1;
                vis_waddr  = sweep_addr;
                vis_wdata  = 1'b0;
                if (sweep_col_reg == LAST_IDX) begin
                    sweep_col_next = '0;
                    sweep_row_next = sweep_row_reg + RW'(1);
                end else begin
                    sweep_col_next = sweep_col_reg + RW'(1);
                end
                if (sweep_last) begin
                    sweep_row_next = '0;
                    sweep_col_next = '0;
                    state_next     = (state_reg == ST_INIT) ? ST_IDLE : ST_EMIT;
                end
            end

            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sense_next = s_tdata[2:0];
                    moved_next = 1'b0;
                    back_next  = 1'b0;
                    stuck_next = 1'b0;
                    found_next = 1'b0;
                    state_next = (s_tuser[0] == OP_CLEAR) ? ST_CLEAR : ST_LOAD;
                end
            end

            ST_LOAD: begin
                cur_cell_next = merged_cell;
                dir_next      = DIR_N;
                state_next    = ST_PROBE;
            end

            ST_PROBE: begin
                if (!probe_blocked) begin
                    state_next = ST_CHECK;
                end else if (dir_reg == DIR_W) begin
                    found_next    = 1'b0;
                    move_dir_next = cur_cell_reg.back_ptr;
                    state_next    = ST_WB_CUR;
                end else begin
                    dir_next = dir_reg + 2'd1;
                end
            end

            ST_CHECK: begin
                if (nb_free) begin
                    found_next    = 1'b1;
                    move_dir_next = dir_reg;
                    nb_cell_next  = rd_cell;
                    state_next    = ST_WB_CUR;
                end else if (dir_reg == DIR_W) begin
                    found_next    = 1'b0;
                    move_dir_next = cur_cell_reg.back_ptr;
                    state_next    = ST_WB_CUR;
                end else begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_PROBE;
                end
            end

            ST_WB_CUR: begin
                cell_we              = 1'b1;
                cell_wdata           = cur_cell_reg;
                cell_wdata[0]        = cur_cell_reg.exhausted | !found_reg;
                vis_we               = 1'b1;
                if (found_reg) begin
                    moved_next = 1'b1;
                    state_next = ST_WB_DST;
                end else begin
                    // Dead end: back up along the back pointer, except at the
                    // start cell or when the pointer leads off the grid.
                    stuck_next = at_origin;
                    moved_next = !at_origin && nbr_ok;
                    back_next  = !at_origin && nbr_ok;
                    state_next = ST_EMIT;
                end
            end

            ST_WB_DST: begin
                cell_we    = 1'b1;
                cell_waddr = nbr_addr;
                cell_wdata = nb_cell_reg;
                cell_wdata[2:1] = move_dir_reg + 2'd2;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {new_col_w[3:0], new_row_w[3:0], stuck_reg, goal_hit,
                                     back_reg, moved_reg, out_turn, out_dir};
                    if (moved_reg) begin
                        heading_next = move_dir_reg;
                        cur_row_next = nbr_row;
                        cur_col_next = nbr_col;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The entered cell is only written after a forward neighbour was found.
    a_dst_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB_DST) |-> found_reg)
        else $error("entered cell written without a forward move");

    // An accepted beat always starts work; the block is not ready next cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // A stuck result never reports a move, and backtracking implies a move.
    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!(m_tdata[7] && m_tdata[4]) && (!m_tdata[5] || m_tdata[4])))
        else $error("inconsistent move flags in result");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for maze_depth_first_explorer_unit.
// Depends on mdfe_pkg and the explorer RTL; needs no files or arguments.
module testbench;
    import mdfe_pkg::*;

    localparam int SIDE           = 16;
    localparam int PHASE_ITEMS    = 188;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // Turn codes as the result beat reports them.
    localparam logic [1:0] TURN_NONE   = 2'd0;
    localparam logic [1:0] TURN_RIGHT  = 2'd1;
    localparam logic [1:0] TURN_AROUND = 2'd2;
    localparam logic [1:0] TURN_LEFT   = 2'd3;

    // Cell byte layout: walls N, E, S, W in bits 7..4, back pointer in
    // bits 3..2, visited in bit 1, exhausted in bit 0.
    localparam logic [7:0] VISIT = 8'h02;
    localparam logic [7:0] SPENT = 8'h01;

    // One result beat. The packed order puts move_dir in the low bits, so
    // the struct lines up with m_tdata bit for bit.
    typedef struct packed {
        logic [3:0] col;
        logic [3:0] row;
        logic       stuck;
        logic       goal;
        logic       back;
        logic       moved;
        logic [1:0] turn;
        logic [1:0] dir;
    } step_t;

    // One input beat.
    typedef struct packed {
        logic op;
        logic front;
        logic left;
        logic right;
    } sense_t;

    // A directed row: the beat, and a result typed in by hand when it is
    // obvious from the maze drawn so far. Other rows go to the predictor.
    typedef struct packed {
        sense_t beat;
        logic   typed;
        step_t  want;
    } dir_row_t;

    localparam step_t NO_STEP = '0;

    // The directed walk builds a small loop in the top left corner. It
    // enters the start cell from the east after a clear, gets stuck there,
    // then clears again and escapes south. Along the way it backtracks twice
    // and leaves through the open south side of row 1, column 0 into the
    // rest of the maze.
    localparam dir_row_t DIRECTED [14] = '{
        // Start cell, wall ahead: first free side is south.
        '{'{OP_EXPLORE, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{dir: DIR_S, turn: TURN_RIGHT, moved: 1'b1, row: 4'd1, default: '0}},
        // Clear of visited marks reports the current cell and no move.
        '{'{OP_CLEAR, 1'b0, 1'b0, 1'b0}, 1'b1, '{row: 4'd1, default: '0}},
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b1}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b1, 1'b0, 1'b1}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b1, 1'b0, 1'b1}, 1'b0, NO_STEP},
        // Back in the start cell with every side closed or visited.
        '{'{OP_EXPLORE, 1'b1, 1'b0, 1'b1}, 1'b1, '{stuck: 1'b1, default: '0}},
        '{'{OP_CLEAR, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP},
        // Dead end at row 0, column 1: back along the pointer, turning around.
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{dir: DIR_S, turn: TURN_AROUND, moved: 1'b1, back: 1'b1,
            row: 4'd1, col: 4'd1, default: '0}},
        '{'{OP_EXPLORE, 1'b0, 1'b0, 1'b0}, 1'b0, NO_STEP},
        // Visited cell: the all-ones wall flags must be ignored.
        '{'{OP_EXPLORE, 1'b1, 1'b1, 1'b1}, 1'b0, NO_STEP},
        '{'{OP_EXPLORE, 1'b0, 1'b1, 1'b0}, 1'b0, NO_STEP}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    maze_depth_first_explorer_unit #(.GRID_SIDE(SIDE)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Explorer state as the testbench sees it.
    logic [7:0] cell_mem [SIDE*SIDE];
    int         at_row;
    int         at_col;
    logic [1:0] facing;
    int         goal_r;
    int         goal_c;

    // The hidden maze that the sensor beats describe: one flag per cell for a wall
    // on its east side and one for its south side, the border closed.
    bit         maze_east  [SIDE*SIDE];
    bit         maze_south [SIDE*SIDE];

    step_t      pending_steps [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         hold = 0;
    bit         calm = 1'b0;

    function automatic logic [7:0] wall_mask(input logic [1:0] d);
        return 8'h80 >> d;
    endfunction

    // Neighbour of (r, c) toward d; returns 0 when it would leave the grid.
    function automatic bit step_to(input int r, input int c, input logic [1:0] d,
                                   output int nr, output int nc);
        nr = r;
        nc = c;
        case (d)
            DIR_N: if (r == 0) return 1'b0; else nr = r - 1;
            DIR_E: if (c == SIDE - 1) return 1'b0; else nc = c + 1;
            DIR_S: if (r == SIDE - 1) return 1'b0; else nr = r + 1;
            default: if (c == 0) return 1'b0; else nc = c - 1;
        endcase
        return 1'b1;
    endfunction

    function automatic void reset_explorer();
        logic [7:0] v;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                v = '0;
                if (r == 0) v |= wall_mask(DIR_N);
                if (r == SIDE - 1) v |= wall_mask(DIR_S);
                if (c == 0) v |= wall_mask(DIR_W);
                if (c == SIDE - 1) v |= wall_mask(DIR_E);
                cell_mem[r*SIDE + c] = v;
            end
        end
        at_row = 0;
        at_col = 0;
        facing = DIR_E;
        goal_r = int'(GOAL_RESET);
        goal_c = int'(GOAL_RESET);
    endfunction

    // Works out the result of one accepted beat and advances the state.
    function automatic step_t explore_step(input sense_t b);
        step_t      res;
        logic [7:0] here;
        logic [1:0] back_dir;
        logic [1:0] d;
        bit         found;
        int         idx;
        int         nr;
        int         nc;
        int         k;
        res = '0;
        if (b.op == OP_CLEAR) begin
            for (k = 0; k < SIDE*SIDE; k++) cell_mem[k] &= ~VISIT;
        end else begin
            idx = at_row*SIDE + at_col;
            here = cell_mem[idx];
            // Sensed walls count only on the first visit, rotated by heading.
            if ((here & VISIT) == 0) begin
                if (b.front) here |= wall_mask(facing);
                if (b.left) here |= wall_mask(facing + 2'd3);
                if (b.right) here |= wall_mask(facing + 2'd1);
                here |= VISIT;
            end
            back_dir = here[3:2];
            found = 1'b0;
            for (k = 0; k < 4 && !found; k++) begin
                d = k[1:0];
                if ((here & wall_mask(d)) == 0 && d != back_dir) begin
                    if (step_to(at_row, at_col, d, nr, nc)) begin
                        if ((cell_mem[nr*SIDE + nc] & (VISIT | SPENT)) == 0) begin
                            found = 1'b1;
                            res.dir = d;
                        end
                    end
                end
            end
            if (!found) here |= SPENT;
            cell_mem[idx] = here;
            if (found) begin
                void'(step_to(at_row, at_col, res.dir, nr, nc));
                cell_mem[nr*SIDE + nc][3:2] = res.dir + 2'd2;
                res.moved = 1'b1;
            end else if (at_row == 0 && at_col == 0) begin
                res.stuck = 1'b1;
            end else if (step_to(at_row, at_col, back_dir, nr, nc)) begin
                // Backtracking trusts the pointer and ignores the walls.
                res.dir = back_dir;
                res.moved = 1'b1;
                res.back = 1'b1;
            end
            if (res.moved) begin
                res.turn = res.dir - facing;
                facing = res.dir;
                at_row = nr;
                at_col = nc;
            end
        end
        res.goal = (at_row == goal_r || at_row == goal_r + 1) &&
                   (at_col == goal_c || at_col == goal_c + 1);
        res.row = at_row[3:0];
        res.col = at_col[3:0];
        return res;
    endfunction

    function automatic bit maze_wall(input int r, input int c, input logic [1:0] d);
        case (d)
            DIR_N: return (r == 0) ? 1'b1 : maze_south[(r-1)*SIDE + c];
            DIR_E: return (c == SIDE - 1) ? 1'b1 : maze_east[r*SIDE + c];
            DIR_S: return (r == SIDE - 1) ? 1'b1 : maze_south[r*SIDE + c];
            default: return (c == 0) ? 1'b1 : maze_east[r*SIDE + c - 1];
        endcase
    endfunction

    // Mostly honest sensor readings of the hidden maze at the current cell,
    // with a few noisy readings and the odd clear of the visited marks.
    function automatic sense_t next_beat();
        sense_t b;
        int     pick;
        pick = $urandom_range(0, 99);
        b.op = OP_EXPLORE;
        if (pick < 3) begin
            b = sense_t'({1'b0, 3'($urandom_range(0, 7))});
            b.op = OP_CLEAR;
        end else if (pick < 9) begin
            b = sense_t'({1'b0, 3'($urandom_range(0, 7))});
            b.op = OP_EXPLORE;
        end else begin
            b.front = maze_wall(at_row, at_col, facing);
            b.left  = maze_wall(at_row, at_col, facing + 2'd3);
            b.right = maze_wall(at_row, at_col, facing + 2'd1);
        end
        return b;
    endfunction

    // Idle stretch: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drives one beat and files its expected result once it is taken.
    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic push_beat(input sense_t b, input step_t want);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b.right, b.left, b.front};
        s_tuser  <= b.op;
        do @(posedge aclk); while (!s_tready);
        pending_steps.push_back(want);
    endtask

    task automatic set_goal(input logic [3:0] row, input logic [3:0] col);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GOAL_ROW;
        cfg_wdata <= row;
        @(posedge aclk);
        cfg_index <= CFG_GOAL_COL;
        cfg_wdata <= col;
        @(posedge aclk);
        cfg_we <= 1'b0;
        goal_r = int'(row);
        goal_c = int'(col);
    endtask

    task automatic wait_idle();
        while (pending_steps.size() != 0) @(posedge aclk);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_step(input logic [15:0] data);
        step_t got;
        step_t want;
        got = data;
        if (pending_steps.size() == 0) begin
            mismatches++;
            $display("%0t: result beat %h with nothing pending", $time, data);
        end else begin
            want = pending_steps.pop_front();
            compare_field("move_dir", int'(want.dir), int'(got.dir));
            compare_field("turn", int'(want.turn), int'(got.turn));
            compare_field("moved", int'(want.moved), int'(got.moved));
            compare_field("backtracking", int'(want.back), int'(got.back));
            compare_field("goal_reached", int'(want.goal), int'(got.goal));
            compare_field("stuck", int'(want.stuck), int'(got.stuck));
            compare_field("pos_row", int'(want.row), int'(got.row));
            compare_field("pos_col", int'(want.col), int'(got.col));
        end
    endtask

    // Result side: checks every beat taken and stalls at random.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_step(m_tdata);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                hold = idle_len();
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too
    // long. The limit covers the fill pass after reset and a full clear
    // sweep stacked with the longest stalls on both sides.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        step_t      want;
        sense_t     b;
        logic [3:0] gr;
        logic [3:0] gc;
        reset_explorer();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk with the goal registers still at their reset value.
        for (int i = 0; i < 14; i++) begin
            want = explore_step(DIRECTED[i].beat);
            if (DIRECTED[i].typed) want = DIRECTED[i].want;
            push_beat(DIRECTED[i].beat, want);
        end
        s_tvalid <= 1'b0;
        wait_idle();

        // A fairly open hidden maze keeps the search going for a long time.
        for (int i = 0; i < SIDE*SIDE; i++) begin
            maze_east[i]  = ($urandom_range(0, 99) < 25);
            maze_south[i] = ($urandom_range(0, 99) < 25);
        end

        // Random phases, each with its own goal square: the four corner
        // extremes and one random square. The middle phase runs without
        // idle cycles on either side.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin gr = 4'd0;  gc = 4'd0;  end
                1: begin gr = 4'd14; gc = 4'd14; end
                2: begin
                    gr = 4'($urandom_range(0, 14));
                    gc = 4'($urandom_range(0, 14));
                end
                3: begin gr = 4'd0;  gc = 4'd14; end
                default: begin gr = 4'd14; gc = 4'd0; end
            endcase
            set_goal(gr, gc);
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                b = next_beat();
                want = explore_step(b);
                push_beat(b, want);
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end

        // Any late extra beat would show up as unexpected during this pause.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_steps.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
